// ----- hw/rtl/wahp_pkg.sv -----
// Shared types and constants for the WAV/AIFF header parser.
// Used by the controller, the datapath and the top level; no dependencies.
package wahp_pkg;

	localparam int MAX_CHUNKS_DEF = 64;
	localparam int DIV_STEPS      = 42;
	localparam int DVD_W          = 42;
	localparam int RES_W          = 75;
	localparam int DATA_W         = 72;
	localparam int USER_W         = 3;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;
	localparam logic [31:0] TAG_FORM = 32'h464F524D;
	localparam logic [31:0] TAG_AIFF = 32'h41494646;
	localparam logic [31:0] TAG_AIFC = 32'h41494643;
	localparam logic [31:0] TAG_COMM = 32'h434F4D4D;

	localparam logic [14:0] EXP_BIAS = 15'd16383;
	localparam logic [14:0] EXP_TOP  = 15'd16446;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_WAV  = 2'd1,
		KIND_AIFF = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_CHDR   = 5'b00010,
		PH_BODY   = 5'b00100,
		PH_SKIP   = 5'b01000,
		PH_IGNORE = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		ST_RUN  = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic emit;
	} wahp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_req;
		logic div_done;
	} wahp_status_t;

endpackage

// ----- hw/rtl/wahp_ctrl.sv -----
// Controller state machine of the WAV/AIFF header parser.
// Depends on wahp_pkg; drives the datapath through wahp_cmd_t.
module wahp_ctrl
	import wahp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_last,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  wahp_status_t status,
	output wahp_cmd_t    cmd
);

	ctrl_state_t state_q, state_n;
	logic        last_q;
	logic        out_valid_q;
	logic        out_free;

	assign in_ready  = (state_q == ST_RUN);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Commands follow from the state and the handshakes.
	always_comb begin
		cmd.take = in_valid && (state_q == ST_RUN);
		cmd.emit = (state_q == ST_EMIT) && out_free;
	end

	// Next state: a division holds off input, the result waits for a free slot.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (cmd.take) begin
					if (status.div_req) state_n = ST_DIV;
					else if (in_last)   state_n = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (status.div_done) state_n = last_q ? ST_EMIT : ST_RUN;
			end
			ST_EMIT: begin
				if (out_free) state_n = ST_RUN;
			end
			default: state_n = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.take) last_q <= in_last;
			if (cmd.emit)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/wahp_dp.sv -----
// Datapath of the WAV/AIFF header parser: byte parsing registers, body
// buffer, serial divider for the duration and the result register.
// Depends on wahp_pkg.
module wahp_dp
	import wahp_pkg::*;
#(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         in_byte,
	input  wahp_cmd_t          cmd,
	output wahp_status_t       status,
	output logic [RES_W-1:0]   result
);

	localparam int SEEN_W = $clog2(MAX_CHUNKS + 1);
	localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_CHUNKS);

	// Parse registers.
	phase_t            phase_q, phase_n;
	logic [4:0]        pos_q, pos_n;
	logic [31:0]       tag_q, tag_n;
	logic [31:0]       len_q, len_n;
	logic [32:0]       skip_q, skip_n;
	logic [SEEN_W-1:0] seen_q, seen_n;
	kind_t             kind_q, kind_n;
	logic [7:0]        buf_q [18];
	logic [7:0]        buf_n [18];
	logic [31:0]       bps_q, bps_n;
	logic [7:0]        ch_q, ch_n;
	logic [31:0]       rate_q, rate_n;
	logic [31:0]       dur_q;

	// Division request and its operands.
	logic              div_req;
	logic [31:0]       div_cnt_n, div_dsr_n;

	// Serial divider registers.
	logic              busy_q;
	logic [5:0]        step_q;
	logic [31:0]       cnt_q;
	logic [31:0]       dsr_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [32:0]       rem_q;
	logic [32:0]       rem_sh, rem_nx;
	logic              ge;
	logic [DVD_W-1:0]  q_nx;
	logic              last_step;

	logic [RES_W-1:0]  result_q;

	// Helpers on the body buffer with the current byte written in.
	logic [14:0] rate_exp;
	logic [63:0] rate_man;
	logic [5:0]  rate_sh;
	logic [31:0] ext_rate;
	logic [31:0] frames;
	logic        body_full;
	logic        ok;

	always_comb begin
		for (int i = 0; i < 18; i++) begin
			buf_n[i] = buf_q[i];
		end
		if (phase_q == PH_BODY && pos_q < 5'd18) buf_n[pos_q] = in_byte;
	end

	// 80-bit extended rate: mantissa shifted down by 63 minus the unbiased exponent.
	always_comb begin
		rate_exp = {buf_n[8][6:0], buf_n[9]};
		rate_man = {buf_n[10], buf_n[11], buf_n[12], buf_n[13],
			buf_n[14], buf_n[15], buf_n[16], buf_n[17]};
		rate_sh  = 6'(EXP_TOP - rate_exp);
		if (rate_exp < EXP_BIAS || rate_exp > EXP_TOP) ext_rate = 32'd0;
		else ext_rate = 32'(rate_man >> rate_sh);
		frames = {buf_n[2], buf_n[3], buf_n[4], buf_n[5]};
	end

	// Byte parsing: next values of the parse registers for the current byte.
	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		tag_n     = tag_q;
		len_n     = len_q;
		skip_n    = skip_q;
		seen_n    = seen_q;
		kind_n    = kind_q;
		bps_n     = bps_q;
		ch_n      = ch_q;
		rate_n    = rate_q;
		div_req   = 1'b0;
		div_cnt_n = frames;
		div_dsr_n = ext_rate;
		body_full = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				tag_n = {tag_q[23:0], in_byte};
				pos_n = pos_q + 5'd1;
				if (pos_q == 5'd3) begin
					if (tag_n == TAG_RIFF)      kind_n = KIND_WAV;
					else if (tag_n == TAG_FORM) kind_n = KIND_AIFF;
					else begin
						kind_n  = KIND_NONE;
						phase_n = PH_IGNORE;
						pos_n   = pos_q;
					end
				end else if (pos_q == 5'd11) begin
					if ((kind_q == KIND_WAV && tag_n == TAG_WAVE) ||
						(kind_q == KIND_AIFF && (tag_n == TAG_AIFF || tag_n == TAG_AIFC))) begin
						pos_n   = 5'd0;
						tag_n   = 32'd0;
						len_n   = 32'd0;
						phase_n = (seen_q >= SEEN_MAX) ? PH_IGNORE : PH_CHDR;
					end else begin
						kind_n  = KIND_NONE;
						phase_n = PH_IGNORE;
						pos_n   = pos_q;
					end
				end
			end
			PH_CHDR: begin
				if (pos_q < 5'd4) begin
					tag_n = {tag_q[23:0], in_byte};
				end else if (kind_q == KIND_WAV) begin
					case (pos_q[1:0])
						2'd0:    len_n[7:0]   = len_q[7:0] | in_byte;
						2'd1:    len_n[15:8]  = len_q[15:8] | in_byte;
						2'd2:    len_n[23:16] = len_q[23:16] | in_byte;
						default: len_n[31:24] = len_q[31:24] | in_byte;
					endcase
				end else begin
					len_n = {len_q[23:0], in_byte};
				end
				if (pos_q < 5'd7) begin
					pos_n = pos_q + 5'd1;
				end else begin
					seen_n = seen_q + SEEN_W'(1);
					skip_n = {1'b0, len_n} + {32'd0, len_n[0]};
					pos_n  = 5'd0;
					if ((kind_q == KIND_WAV && tag_n == TAG_FMT && len_n >= 32'd16) ||
						(kind_q == KIND_AIFF && tag_n == TAG_COMM && len_n >= 32'd18)) begin
						phase_n = PH_BODY;
					end else begin
						if (kind_q == KIND_WAV && tag_n == TAG_DATA && bps_q != 32'd0) begin
							div_req   = 1'b1;
							div_cnt_n = len_n;
							div_dsr_n = bps_q;
						end
						if (skip_n == 33'd0) begin
							tag_n   = 32'd0;
							len_n   = 32'd0;
							phase_n = (seen_n >= SEEN_MAX) ? PH_IGNORE : PH_CHDR;
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end
			end
			PH_BODY: begin
				pos_n = pos_q + 5'd1;
				if (skip_q != 33'd0) skip_n = skip_q - 33'd1;
				body_full = (kind_q == KIND_WAV) ? (pos_n >= 5'd16) : (pos_n >= 5'd18);
				if (body_full) begin
					if (kind_q == KIND_WAV) begin
						ch_n   = buf_n[2];
						rate_n = {buf_n[7], buf_n[6], buf_n[5], buf_n[4]};
						bps_n  = {buf_n[11], buf_n[10], buf_n[9], buf_n[8]};
					end else begin
						ch_n      = buf_n[1];
						rate_n    = ext_rate;
						div_req   = (ext_rate != 32'd0);
						div_cnt_n = frames;
						div_dsr_n = ext_rate;
					end
					if (skip_n == 33'd0) begin
						pos_n   = 5'd0;
						tag_n   = 32'd0;
						len_n   = 32'd0;
						phase_n = (seen_q >= SEEN_MAX) ? PH_IGNORE : PH_CHDR;
					end else begin
						phase_n = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (skip_q != 33'd0) skip_n = skip_q - 33'd1;
				if (skip_n == 33'd0) begin
					pos_n   = 5'd0;
					tag_n   = 32'd0;
					len_n   = 32'd0;
					phase_n = (seen_q >= SEEN_MAX) ? PH_IGNORE : PH_CHDR;
				end
			end
			PH_IGNORE: begin
				phase_n = phase_q;
			end
			default: phase_n = PH_IGNORE;
		endcase
	end

	// One restoring division step per cycle.
	always_comb begin
		rem_sh    = {rem_q[31:0], dvd_q[DVD_W-1]};
		ge        = (rem_sh >= {1'b0, dsr_q});
		rem_nx    = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
		q_nx      = {dvd_q[DVD_W-2:0], ge};
		last_step = busy_q && (step_q == 6'(DIV_STEPS));
	end

	assign status.div_req  = div_req;
	assign status.div_done = last_step;

	// Parse registers, cleared after each result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 5'd0;
			tag_q   <= 32'd0;
			len_q   <= 32'd0;
			skip_q  <= 33'd0;
			seen_q  <= '0;
			kind_q  <= KIND_NONE;
			bps_q   <= 32'd0;
			ch_q    <= 8'd0;
			rate_q  <= 32'd0;
			dur_q   <= 32'd0;
		end else if (cmd.emit) begin
			phase_q <= PH_HEADER;
			pos_q   <= 5'd0;
			tag_q   <= 32'd0;
			len_q   <= 32'd0;
			skip_q  <= 33'd0;
			seen_q  <= '0;
			kind_q  <= KIND_NONE;
			bps_q   <= 32'd0;
			ch_q    <= 8'd0;
			rate_q  <= 32'd0;
			dur_q   <= 32'd0;
		end else begin
			if (cmd.take) begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				tag_q   <= tag_n;
				len_q   <= len_n;
				skip_q  <= skip_n;
				seen_q  <= seen_n;
				kind_q  <= kind_n;
				bps_q   <= bps_n;
				ch_q    <= ch_n;
				rate_q  <= rate_n;
			end
			if (last_step) dur_q <= (|q_nx[DVD_W-1:32]) ? 32'hFFFF_FFFF : q_nx[31:0];
		end
	end

	// Body buffer, written only while a body arrives.
	always_ff @(posedge clk) begin
		if (cmd.take && phase_q == PH_BODY && pos_q < 5'd18) buf_q[pos_q] <= in_byte;
	end

	// Divider control: a first step scales by 1000, then one quotient bit a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 6'd0;
		end else if (cmd.take && div_req) begin
			busy_q <= 1'b1;
			step_q <= 6'd0;
		end else if (busy_q) begin
			busy_q <= !last_step;
			step_q <= step_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && div_req) begin
			cnt_q <= div_cnt_n;
			dsr_q <= div_dsr_n;
		end else if (busy_q && step_q == 6'd0) begin
			dvd_q <= ({10'd0, cnt_q} << 10) - ({10'd0, cnt_q} << 4) - ({10'd0, cnt_q} << 3);
			rem_q <= 33'd0;
		end else if (busy_q) begin
			dvd_q <= q_nx;
			rem_q <= rem_nx;
		end
	end

	// Result register.
	assign ok = (phase_q != PH_HEADER) && (kind_q != KIND_NONE);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q <= ok ? {dur_q, rate_q, ch_q, kind_q, 1'b1} : '0;
		end
	end

	assign result = result_q;

endmodule

// ----- hw/rtl/wav_aiff_audio_header_parser_unit.sv -----
// WAV/AIFF header parser, top level: controller and datapath.
// Takes one byte per cycle while no division runs and no result waits; a data or COMM
// chunk that sets a duration stalls input for a scaling step, then a 42-step serial divider.
// After the last byte the result is registered, after the division if one runs.
// Reset (arst_n low, asynchronous) clears all parse state and the output valid.
module wav_aiff_audio_header_parser_unit
	import wahp_pkg::*;
#(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tlast,   // last_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	// [7:0] channels, [39:8] rate in hertz, [71:40] play time in milliseconds
	output logic [DATA_W-1:0] m_tdata,
	// [0] accepted, [2:1] container
	output logic [USER_W-1:0] m_tuser
);

	wahp_cmd_t        cmd;
	wahp_status_t     status;
	logic [RES_W-1:0] result;

	wahp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	wahp_dp #(
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (s_tdata),
		.cmd     (cmd),
		.status  (status),
		.result  (result)
	);

	// The flags travel beside the data fields.
	assign m_tuser = result[USER_W-1:0];
	assign m_tdata = result[RES_W-1:USER_W];

endmodule

// ----- verif/tb_wav_aiff_audio_header_parser_unit.sv -----
// Testbench for the WAV/AIFF header parser: directed files from a table and two built
// ones, then random well-formed and broken files, checked against a behavioural predictor.
// Depends on wahp_pkg and wav_aiff_audio_header_parser_unit.
module tb_wav_aiff_audio_header_parser_unit;
	import wahp_pkg::*;

	typedef struct packed {
		logic [31:0] play_ms;
		logic [31:0] rate_hz;
		logic [7:0]  channels;
		logic [1:0]  container;
		logic        accepted;
	} summary_t;

	typedef enum logic [2:0] {
		P_HEADER, P_CHDR, P_BODY, P_SKIP, P_IGNORE
	} pred_phase_t;

	typedef struct {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       typed;
		summary_t   summary;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic [USER_W-1:0] m_tuser;

	wav_aiff_audio_header_parser_unit dut (.*);

	// Predictor state, mirroring the parser.
	pred_phase_t p_phase;
	int unsigned p_pos;
	logic [31:0] p_tag;
	logic [31:0] p_len;
	logic [32:0] p_skip;
	int unsigned p_chunks;
	kind_t       p_kind;
	logic [7:0]  p_body [18];
	logic [31:0] p_bps;
	logic [7:0]  p_chan;
	logic [31:0] p_rate;
	logic [31:0] p_dur;

	summary_t  expected_summaries[$];
	int        fail_count;
	logic      hold_off;
	logic      bulk_hold;
	logic      hold_done;
	logic      drained;
	logic [7:0] file_bytes[$];

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [31:0] scaled_quotient(logic [31:0] count, logic [31:0] divisor);
		logic [63:0] q;
		q = (64'(count) * 64'd1000) / 64'(divisor);
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic void clear_parser();
		p_phase = P_HEADER;
		p_pos = 0;
		p_tag = '0;
		p_len = '0;
		p_skip = '0;
		p_chunks = 0;
		p_kind = KIND_NONE;
		p_bps = '0;
		p_chan = '0;
		p_rate = '0;
		p_dur = '0;
	endfunction

	function automatic void end_chunk();
		p_pos = 0;
		p_tag = '0;
		p_len = '0;
		p_phase = (p_chunks >= MAX_CHUNKS_DEF) ? P_IGNORE : P_CHDR;
	endfunction

	// Applies a complete fmt or COMM body.
	function automatic void apply_format_body();
		logic [14:0] ex;
		logic [63:0] mant;
		logic [31:0] frames;
		if (p_kind == KIND_WAV) begin
			p_chan = p_body[2];
			p_rate = {p_body[7], p_body[6], p_body[5], p_body[4]};
			p_bps  = {p_body[11], p_body[10], p_body[9], p_body[8]};
		end else begin
			frames = {p_body[2], p_body[3], p_body[4], p_body[5]};
			p_chan = p_body[1];
			ex = {p_body[8][6:0], p_body[9]};
			mant = '0;
			for (int i = 0; i < 8; i++) mant = {mant[55:0], p_body[10 + i]};
			if (ex < EXP_BIAS || ex > EXP_TOP) p_rate = '0;
			else p_rate = 32'(mant >> (63 - (ex - EXP_BIAS)));
			if (p_rate != 0) p_dur = scaled_quotient(frames, p_rate);
		end
	endfunction

	// Advances the predictor by one byte and queues a summary on the last one.
	function automatic void predict_byte(logic [7:0] b, logic last);
		logic ok;
		summary_t s;
		case (p_phase)
			P_HEADER: begin
				p_tag = {p_tag[23:0], b};
				if (p_pos == 3) begin
					if (p_tag == TAG_RIFF) p_kind = KIND_WAV;
					else if (p_tag == TAG_FORM) p_kind = KIND_AIFF;
					else begin
						p_kind = KIND_NONE;
						p_phase = P_IGNORE;
					end
					if (p_phase == P_HEADER) p_pos++;
				end else if (p_pos == 11) begin
					ok = (p_kind == KIND_WAV) ? (p_tag == TAG_WAVE)
						: (p_tag == TAG_AIFF || p_tag == TAG_AIFC);
					if (!ok) begin
						p_kind = KIND_NONE;
						p_phase = P_IGNORE;
					end else begin
						end_chunk();
					end
				end else begin
					p_pos++;
				end
			end
			P_CHDR: begin
				if (p_pos < 4) p_tag = {p_tag[23:0], b};
				else if (p_kind == KIND_WAV) p_len = p_len | (32'(b) << (8 * (p_pos - 4)));
				else p_len = {p_len[23:0], b};
				if (p_pos < 7) begin
					p_pos++;
				end else begin
					p_chunks++;
					p_skip = 33'(p_len) + 33'(p_len[0]);
					p_pos = 0;
					if ((p_kind == KIND_WAV && p_tag == TAG_FMT && p_len >= 16) ||
					    (p_kind == KIND_AIFF && p_tag == TAG_COMM && p_len >= 18)) begin
						p_phase = P_BODY;
					end else begin
						if (p_kind == KIND_WAV && p_tag == TAG_DATA && p_bps != 0)
							p_dur = scaled_quotient(p_len, p_bps);
						if (p_skip == 0) end_chunk();
						else p_phase = P_SKIP;
					end
				end
			end
			P_BODY: begin
				if (p_pos < 18) p_body[p_pos] = b;
				p_pos++;
				if (p_skip != 0) p_skip--;
				if (p_pos >= ((p_kind == KIND_WAV) ? 16 : 18)) begin
					apply_format_body();
					if (p_skip == 0) end_chunk();
					else p_phase = P_SKIP;
				end
			end
			P_SKIP: begin
				if (p_skip != 0) p_skip--;
				if (p_skip == 0) end_chunk();
			end
			default: ;
		endcase
		if (last) begin
			ok = (p_phase != P_HEADER) && (p_kind != KIND_NONE);
			s.accepted  = ok;
			s.container = ok ? p_kind : KIND_NONE;
			s.channels  = ok ? p_chan : '0;
			s.rate_hz   = ok ? p_rate : '0;
			s.play_ms   = ok ? p_dur : '0;
			expected_summaries.push_back(s);
			clear_parser();
		end
	endfunction

	// Sends one item, with the sender's burst and gap pattern.
	int burst_left;
	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_byte(b, last);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
	endtask

	function automatic void put32(logic [31:0] v, logic little);
		for (int i = 0; i < 4; i++)
			file_bytes.push_back(little ? v[8 * i +: 8] : v[8 * (3 - i) +: 8]);
	endfunction

	function automatic void add_chunk(logic [31:0] tag, logic [31:0] len, int body_bytes,
					  logic little, logic [7:0] body [18]);
		put32(tag, 1'b0);
		put32(len, little);
		for (int i = 0; i < body_bytes; i++)
			file_bytes.push_back(i < 18 ? body[i] : 8'($urandom));
	endfunction

	// Builds a random file: mostly well formed, some noise and cut files.
	function automatic void build_file();
		logic        wav;
		logic [7:0]  body [18];
		logic [31:0] len;
		int          n;
		int          style;
		file_bytes.delete();
		style = $urandom_range(0, 9);
		wav = 1'($urandom_range(0, 1));
		if (style == 0) begin
			n = $urandom_range(1, 20);
			for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
			return;
		end
		put32(wav ? TAG_RIFF : TAG_FORM, 1'b0);
		put32($urandom, wav);
		put32(wav ? TAG_WAVE : ($urandom_range(0, 1) ? TAG_AIFF : TAG_AIFC), 1'b0);
		if (style == 1) file_bytes[$urandom_range(0, 11)] = 8'($urandom);
		n = $urandom_range(1, 3);
		for (int c = 0; c < n; c++) begin
			for (int i = 0; i < 18; i++) body[i] = 8'($urandom);
			if (!wav) begin
				body[8] = {1'($urandom), 7'h40};
				body[9] = 8'($urandom_range(14, 80));
				if ($urandom_range(0, 3) == 0) body[9] = 8'($urandom);
				if ($urandom_range(0, 3) == 0) body[10] = 8'h00;
			end else if ($urandom_range(0, 3) == 0) begin
				body[8] = '0; body[9] = '0; body[10] = '0; body[11] = '0;
			end
			case ($urandom_range(0, 4))
				0: begin
					len = $urandom_range(0, 5);
					add_chunk(32'($urandom), len, int'(len) + int'(len[0]), wav, body);
				end
				1: begin
					len = wav ? $urandom_range(16, 21) : $urandom_range(18, 23);
					add_chunk(wav ? TAG_FMT : TAG_COMM, len, int'(len) + int'(len[0]),
						  wav, body);
				end
				2: begin
					len = $urandom_range(0, 1) ? 32'($urandom) : $urandom_range(0, 5);
					add_chunk(TAG_DATA, len, (len < 6) ? int'(len) + int'(len[0]) : 0,
						  wav, body);
					break;
				end
				3: add_chunk(wav ? TAG_FMT : TAG_COMM, $urandom_range(0, 30),
					     $urandom_range(0, 12), wav, body);
				default: begin
					len = wav ? 16 : 18;
					add_chunk(wav ? TAG_FMT : TAG_COMM, len, int'(len), wav, body);
				end
			endcase
		end
		if ($urandom_range(0, 4) == 0) file_bytes.push_back(8'($urandom));
	endfunction

	// Receiver: random stalls, and one long hold-off counted here.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (bulk_hold) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				bulk_hold = 1'b0;
			end
			m_tready <= hold_off ? 1'b1 : ($urandom_range(0, 2) != 0);
		end
	end

	// Result checker.
	summary_t got;
	summary_t want;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = summary_t'({m_tdata, m_tuser});
			if (expected_summaries.size() == 0) begin
				$error("unexpected result %h %h", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = expected_summaries.pop_front();
				if (got.accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
					fail_count++;
				end
				if (got.container !== want.container) begin
					$error("container: expected %0d, got %0d", want.container, got.container);
					fail_count++;
				end
				if (got.channels !== want.channels) begin
					$error("channels: expected %0d, got %0d", want.channels, got.channels);
					fail_count++;
				end
				if (got.rate_hz !== want.rate_hz) begin
					$error("rate_hz: expected %0d, got %0d", want.rate_hz,
					       got.rate_hz);
					fail_count++;
				end
				if (got.play_ms !== want.play_ms) begin
					$error("play_ms: expected %0d, got %0d", want.play_ms,
					       got.play_ms);
					fail_count++;
				end
			end
		end
	end

	// Directed table: short files and a bad header; extremes of a WAV and an AIFF file follow.
	stim_row_t directed [$];
	task automatic push_row(logic [7:0] b, logic last, logic typed, summary_t s);
		stim_row_t r;
		r.data_byte = b;
		r.last_byte = last;
		r.typed = typed;
		r.summary = s;
		directed.push_back(r);
	endtask

	int items_sent;
	int waited;
	logic [7:0] body [18];
	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		hold_off = 1'b0;
		bulk_hold = 1'b0;
		hold_done = 1'b0;
		drained = 1'b0;
		fail_count = 0;
		burst_left = 0;
		clear_parser();
		// One-byte file at the top value, then a bad header.
		push_row(8'hFF, 1'b1, 1'b1, '0);
		push_row(8'h00, 1'b0, 1'b0, '0);
		push_row(8'h52, 1'b0, 1'b0, '0);
		push_row(8'h49, 1'b0, 1'b0, '0);
		push_row(8'h46, 1'b0, 1'b0, '0);
		push_row(8'h46, 1'b1, 1'b1, '0);
		// WAV header cut after RIFF: not accepted.
		push_row(8'h52, 1'b0, 1'b0, '0);
		push_row(8'h49, 1'b0, 1'b0, '0);
		push_row(8'h46, 1'b0, 1'b0, '0);
		push_row(8'h46, 1'b1, 1'b1, '0);
		wait (arst_n);
		@(negedge clk);
		foreach (directed[i]) begin
			send_byte(directed[i].data_byte, directed[i].last_byte);
			if (directed[i].typed) expected_summaries[$] = directed[i].summary;
		end
		items_sent = directed.size();
		// Full WAV with maximum rates and an oversized data chunk, then AIFF extremes.
		file_bytes.delete();
		put32(TAG_RIFF, 1'b0); put32('1, 1'b1); put32(TAG_WAVE, 1'b0);
		for (int i = 0; i < 18; i++) body[i] = 8'hFF;
		add_chunk(TAG_FMT, 17, 18, 1'b1, body);
		add_chunk(TAG_DATA, 32'hFFFF_FFFF, 0, 1'b1, body);
		items_sent += file_bytes.size();
		send_file();
		file_bytes.delete();
		put32(TAG_FORM, 1'b0); put32(0, 1'b0); put32(TAG_AIFC, 1'b0);
		for (int i = 0; i < 18; i++) body[i] = 8'h00;
		body[1] = 8'h02; body[5] = 8'h10; body[8] = 8'h40; body[9] = 8'h0E; body[10] = 8'hAC;
		add_chunk(TAG_COMM, 18, 18, 1'b0, body);
		items_sent += file_bytes.size();
		send_file();

		// Random files; the long hold-off and a full drain happen partway through.
		while (items_sent < 850) begin
			if (!hold_done && items_sent > 300) begin
				bulk_hold = 1'b1;
				hold_done = 1'b1;
			end
			build_file();
			items_sent += file_bytes.size();
			send_file();
			if ($urandom_range(0, 15) == 0 || (!drained && items_sent > 550)) begin
				drained = 1'b1;
				s_tvalid <= 1'b0;
				@(negedge clk);
				while (expected_summaries.size() != 0) @(negedge clk);
			end
		end
		s_tvalid <= 1'b0;
		hold_off = 1'b1;
		waited = 0;
		while (expected_summaries.size() != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (60) @(negedge clk);
		if (fail_count == 0 && expected_summaries.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
